// ===== src/mdbrx_pkg.sv =====
// Package for the MDB receive frame checker: shared codes and item types.
// No dependencies; the interface file and the top level use it by scoped names.
`default_nettype none

package mdbrx_pkg;

	// Request command codes.
	localparam logic [1:0] CMD_RECV  = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// Reply codes sent back on the bus.
	localparam logic [1:0] RP_NONE = 2'd0;
	localparam logic [1:0] RP_ACK  = 2'd1;
	localparam logic [1:0] RP_NAK  = 2'd2;

	// Frame status codes.
	localparam logic [2:0] ST_START = 3'd0;
	localparam logic [2:0] ST_DATA  = 3'd1;
	localparam logic [2:0] ST_OK    = 3'd2;
	localparam logic [2:0] ST_CKERR = 3'd3;
	localparam logic [2:0] ST_RANGE = 3'd4;

	// One request on the input channel.
	typedef struct packed {
		logic [1:0] command;
		logic [7:0] rx_byte;
		logic       last_byte_flag;
		logic       line_error;
	} rx_item_t;

	// One result on the output channel.
	typedef struct packed {
		logic [1:0] reply;
		logic [2:0] frame_status;
		logic [7:0] read_data;
		logic       not_empty;
	} rx_result_t;

endpackage

`default_nettype wire

// ===== src/mdbrx_if.sv =====
// Valid/ready channel interface used for requests and results.
// Depends on mdbrx_pkg for the default payload type.
`default_nettype none

interface mdbrx_if #(
	parameter type payload_t = mdbrx_pkg::rx_item_t
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/mdb_receive_frame_checker.sv =====
// Top level of the MDB receive frame checker: buffer, checksum and replies.
// Depends on mdbrx_pkg and the mdbrx_if channel interface.
//
//   Channel   Direction   Payload         Handshake
//   req       in          rx_item_t       valid/ready
//   rsp       out         rx_result_t     valid/ready
//   cfg       in          mdb_mode bit    cfg_we, no wait
//
// Each request passes through the input register and then the result register;
// a new request is taken every cycle unless the result is stalled.
// The receive buffer is a one-write, one-read memory whose head entry is
// read into a register ahead of use, with a bypass for a write to the same entry.
// Reset clears all entry valid bits at once, so no clearing pass is needed.
// A stalled result holds the input register, which then holds the request.
`default_nettype none

module mdb_receive_frame_checker #(
	parameter int BUFFER_DEPTH = 64
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_we,
	input  wire logic  cfg_wdata,
	mdbrx_if.sink      req,
	mdbrx_if.source    rsp
);

	localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int WW = $clog2(BUFFER_DEPTH + 1);

	// Configuration register.
	logic mdb_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mdb_mode_q <= 1'b0;
		end else if (cfg_we) begin
			mdb_mode_q <= cfg_wdata;
		end
	end

	// Input register and result register with handshake.
	logic                   valid_s1;
	mdbrx_pkg::rx_item_t    item_s1;
	logic                   res_valid_q;
	mdbrx_pkg::rx_result_t  res_q;
	logic                   advance;

	assign advance   = valid_s1 && (!res_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1 <= req.payload;
		end
	end

	// Frame state.
	logic [WW-1:0] wr_idx_q;
	logic [AW-1:0] rd_idx_q;
	logic [2:0]    status_q;
	logic [7:0]    sum_q;

	// Buffer memory, entry valid bits and head prefetch.
	logic [7:0]              buf_mem [BUFFER_DEPTH];
	logic [BUFFER_DEPTH-1:0] entry_vld_q;
	logic [7:0]              mem_rd_q;
	logic                    byp_q;
	logic [7:0]              byp_data_q;
	logic [7:0]              head_byte;

	assign head_byte = entry_vld_q[rd_idx_q] ? (byp_q ? byp_data_q : mem_rd_q) : 8'd0;

	// Next-state logic for one request.
	logic [WW-1:0] wr_d;
	logic [AW-1:0] rd_d;
	logic [AW-1:0] rd_inc;
	logic [2:0]    status_d;
	logic [7:0]    sum_d;
	logic [7:0]    sum_base;
	logic [1:0]    reply_d;
	logic [7:0]    data_d;
	logic          wen;
	logic          vclr;
	logic          full;

	assign full     = (wr_idx_q == WW'(BUFFER_DEPTH));
	assign rd_inc   = (rd_idx_q == AW'(BUFFER_DEPTH - 1)) ? '0 : rd_idx_q + AW'(1);
	assign sum_base = (status_q == mdbrx_pkg::ST_START) ? 8'd0 : sum_q;

	always_comb begin
		wr_d     = wr_idx_q;
		rd_d     = rd_idx_q;
		status_d = status_q;
		sum_d    = sum_q;
		reply_d  = mdbrx_pkg::RP_NONE;
		data_d   = 8'd0;
		wen      = 1'b0;
		vclr     = 1'b0;
		unique case (item_s1.command)
			mdbrx_pkg::CMD_RECV: begin
				if (item_s1.last_byte_flag) begin
					// A marked last byte closes the frame in MDB mode.
					if (mdb_mode_q && (status_q == mdbrx_pkg::ST_START ||
							status_q == mdbrx_pkg::ST_DATA)) begin
						if (full) begin
							status_d = mdbrx_pkg::ST_RANGE;
							reply_d  = mdbrx_pkg::RP_NAK;
						end else begin
							wen  = 1'b1;
							wr_d = wr_idx_q + WW'(1);
							if (status_q == mdbrx_pkg::ST_START || item_s1.rx_byte == sum_q) begin
								status_d = mdbrx_pkg::ST_OK;
								reply_d  = mdbrx_pkg::RP_ACK;
							end else begin
								status_d = mdbrx_pkg::ST_CKERR;
								reply_d  = mdbrx_pkg::RP_NAK;
							end
						end
					end
				end else if (!item_s1.line_error) begin
					// An ordinary byte is stored if there is room, and summed in MDB mode.
					if (full) begin
						if (mdb_mode_q) begin
							status_d = mdbrx_pkg::ST_RANGE;
							reply_d  = mdbrx_pkg::RP_NAK;
						end
					end else begin
						wen  = 1'b1;
						wr_d = wr_idx_q + WW'(1);
						if (mdb_mode_q) begin
							sum_d    = sum_base + item_s1.rx_byte;
							status_d = mdbrx_pkg::ST_DATA;
						end
					end
				end
			end
			mdbrx_pkg::CMD_READ: begin
				data_d = head_byte;
				vclr   = 1'b1;
				rd_d   = rd_inc;
			end
			mdbrx_pkg::CMD_CLEAR: begin
				wr_d     = '0;
				rd_d     = '0;
				status_d = mdbrx_pkg::ST_START;
			end
			default: begin
			end
		endcase
		if (!advance) begin
			wr_d     = wr_idx_q;
			rd_d     = rd_idx_q;
			status_d = status_q;
			sum_d    = sum_q;
			wen      = 1'b0;
			vclr     = 1'b0;
		end
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			status_q <= mdbrx_pkg::ST_START;
			sum_q    <= 8'd0;
		end else begin
			wr_idx_q <= wr_d;
			rd_idx_q <= rd_d;
			status_q <= status_d;
			sum_q    <= sum_d;
		end
	end

	// Entry valid bits: set on write, cleared when the entry is read out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_vld_q <= '0;
			byp_q       <= 1'b0;
		end else begin
			if (wen) begin
				entry_vld_q[wr_idx_q[AW-1:0]] <= 1'b1;
			end
			if (vclr) begin
				entry_vld_q[rd_idx_q] <= 1'b0;
			end
			byp_q <= wen && (wr_idx_q[AW-1:0] == rd_d);
		end
	end

	// Memory write port and registered read of the next head entry.
	always_ff @(posedge clk) begin
		if (wen) begin
			buf_mem[wr_idx_q[AW-1:0]] <= item_s1.rx_byte;
		end
		mem_rd_q   <= buf_mem[rd_d];
		byp_data_q <= item_s1.rx_byte;
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!res_valid_q || rsp.ready) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.reply        <= reply_d;
			res_q.frame_status <= status_d;
			res_q.read_data    <= data_d;
			res_q.not_empty    <= (WW'(rd_d) != wr_d);
		end
	end

	assign rsp.valid   = res_valid_q;
	assign rsp.payload = res_q;

	// Assertions.
	a_wr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wr_idx_q <= WW'(BUFFER_DEPTH))
		else $error("write index beyond buffer depth");

	a_rd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_idx_q <= AW'(BUFFER_DEPTH - 1))
		else $error("read index beyond last entry");

	a_ack_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.payload.reply == mdbrx_pkg::RP_ACK |->
			rsp.payload.frame_status == mdbrx_pkg::ST_OK)
		else $error("ACK without ok status");

	a_nak_err: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.payload.reply == mdbrx_pkg::RP_NAK |->
			(rsp.payload.frame_status == mdbrx_pkg::ST_CKERR ||
			 rsp.payload.frame_status == mdbrx_pkg::ST_RANGE))
		else $error("NAK without error status");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.command == mdbrx_pkg::CMD_CLEAR |=>
			wr_idx_q == '0 && rd_idx_q == '0 && status_q == mdbrx_pkg::ST_START)
		else $error("clear did not reset indices and status");

endmodule

`default_nettype wire

// ===== dv/mdb_receive_frame_checker_test.sv =====
`timescale 1ns / 1ps
// Testbench for the MDB receive frame checker: a queued request driver, a result
// monitor and a predictor of buffer, checksum, status and reply behavior.
// Depends on mdbrx_pkg, mdbrx_if and mdb_receive_frame_checker.

module mdb_receive_frame_checker_test;

	localparam int BUFFER_DEPTH = 64;
	localparam int IDLE_LIMIT = 4000;
	localparam int RANDOM_PHASES = 5;
	localparam int PHASE_BUDGET = 235;

	// The one command code the block leaves unused.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	mdbrx_if #(.payload_t(mdbrx_pkg::rx_item_t)) req_ch ();
	mdbrx_if #(.payload_t(mdbrx_pkg::rx_result_t)) rsp_ch ();

	mdb_receive_frame_checker #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Predicted state of the block: buffer, indices, status, checksum and mode.
	logic [7:0] model_mem [BUFFER_DEPTH] = '{default: 8'h00};
	int         model_wr = 0;
	int         model_rd = 0;
	logic [2:0] model_status = mdbrx_pkg::ST_START;
	logic [7:0] model_sum = 8'h00;
	logic       model_mode;

	// Requests waiting to be sent and results waiting to arrive.
	mdbrx_pkg::rx_item_t   request_queue[$];
	mdbrx_pkg::rx_result_t expected_results[$];

	// Generator bookkeeping, used to build frames whose checksum mostly matches.
	int         gen_fill = 0;
	logic [7:0] gen_sum = 8'h00;
	logic       gen_fresh = 1'b1;
	int         work_items = 0;

	// Handshake pacing and run statistics.
	logic       calm = 1'b0;
	int         send_gap = 0;
	int         hold_gap = 0;
	int         quiet_cycles = 0;
	int         requests_taken = 0;
	int         results_checked = 0;
	int         mismatches = 0;
	int         ack_count = 0;
	int         nak_count = 0;
	int         ckerr_count = 0;
	int         full_count = 0;
	mdbrx_pkg::rx_result_t want;

	always #4 clk = ~clk;

	// Apply one request to the predicted state and return the result it gives.
	function automatic mdbrx_pkg::rx_result_t predict_frame_result(
			input mdbrx_pkg::rx_item_t rq);
		mdbrx_pkg::rx_result_t res;
		res = '0;
		case (rq.command)
			mdbrx_pkg::CMD_RECV: begin
				if (rq.last_byte_flag) begin
					// A marked byte counts as last even with a line error.
					if (model_mode && (model_status == mdbrx_pkg::ST_START ||
							model_status == mdbrx_pkg::ST_DATA)) begin
						if (model_wr >= BUFFER_DEPTH) begin
							model_status = mdbrx_pkg::ST_RANGE;
							res.reply = mdbrx_pkg::RP_NAK;
						end else begin
							model_mem[model_wr] = rq.rx_byte;
							model_wr++;
							if (model_status == mdbrx_pkg::ST_START ||
									rq.rx_byte == model_sum) begin
								model_status = mdbrx_pkg::ST_OK;
								res.reply = mdbrx_pkg::RP_ACK;
							end else begin
								model_status = mdbrx_pkg::ST_CKERR;
								res.reply = mdbrx_pkg::RP_NAK;
							end
						end
					end
				end else if (!rq.line_error) begin
					if (model_wr >= BUFFER_DEPTH) begin
						if (model_mode) begin
							model_status = mdbrx_pkg::ST_RANGE;
							res.reply = mdbrx_pkg::RP_NAK;
						end
					end else begin
						model_mem[model_wr] = rq.rx_byte;
						model_wr++;
						// The sum restarts only when a frame opens from the start state.
						if (model_mode) begin
							if (model_status == mdbrx_pkg::ST_START)
								model_sum = 8'h00;
							model_status = mdbrx_pkg::ST_DATA;
							model_sum = model_sum + rq.rx_byte;
						end
					end
				end
			end
			mdbrx_pkg::CMD_READ: begin
				// No empty check: the entry is popped, zeroed, and the index wraps.
				res.read_data = model_mem[model_rd];
				model_mem[model_rd] = 8'h00;
				model_rd = (model_rd + 1) % BUFFER_DEPTH;
			end
			mdbrx_pkg::CMD_CLEAR: begin
				model_rd = 0;
				model_wr = 0;
				model_status = mdbrx_pkg::ST_START;
			end
			default: begin
			end
		endcase
		res.frame_status = model_status;
		res.not_empty = (model_rd != model_wr);
		return res;
	endfunction

	// Gap length for either side: mostly none or short, now and then long.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Queue one request and follow the checksum the block should be building.
	task automatic queue_request(input logic [1:0] cmd, input logic [7:0] data,
			input logic last, input logic err);
		mdbrx_pkg::rx_item_t rq;
		rq.command = cmd;
		rq.rx_byte = data;
		rq.last_byte_flag = last;
		rq.line_error = err;
		request_queue.push_back(rq);
		if (cmd == mdbrx_pkg::CMD_CLEAR) begin
			gen_fill = 0;
			gen_fresh = 1'b1;
		end else if (cmd == mdbrx_pkg::CMD_RECV && !last && !err
				&& gen_fill < BUFFER_DEPTH) begin
			if (gen_fresh)
				gen_sum = 8'h00;
			gen_fresh = 1'b0;
			gen_sum = gen_sum + data;
			gen_fill++;
		end else if (cmd == mdbrx_pkg::CMD_RECV && last && model_mode
				&& gen_fill < BUFFER_DEPTH) begin
			gen_fill++;
			gen_fresh = 1'b0;
		end
		// Requests the block simply drops are not counted as work.
		if (cmd == mdbrx_pkg::CMD_READ || cmd == mdbrx_pkg::CMD_CLEAR
				|| (cmd == mdbrx_pkg::CMD_RECV && (last ? model_mode : !err)))
			work_items++;
	endtask

	// A frame: usually a clear, some bytes with stray reads and errors, then a last byte.
	task automatic queue_frame();
		int len;
		int k;
		int roll;
		if ($urandom_range(0, 9) != 0)
			queue_request(mdbrx_pkg::CMD_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom));
		len = ($urandom_range(0, 6) == 0) ? $urandom_range(55, 70) : $urandom_range(0, 10);
		for (k = 0; k < len; k++) begin
			roll = $urandom_range(0, 99);
			if (roll < 8)
				queue_request(mdbrx_pkg::CMD_READ, 8'($urandom), 1'($urandom),
						1'($urandom));
			else if (roll < 16)
				queue_request(mdbrx_pkg::CMD_RECV, 8'($urandom), 1'b0, 1'b1);
			else
				queue_request(mdbrx_pkg::CMD_RECV, 8'($urandom), 1'b0, 1'b0);
		end
		queue_request(mdbrx_pkg::CMD_RECV,
				($urandom_range(0, 3) != 0) ? gen_sum : 8'($urandom), 1'b1,
				1'($urandom_range(0, 4) == 0));
	endtask

	// Random phase: mostly frames, plus runs of reads and fully random requests.
	task automatic fill_random_phase(input int budget);
		int start_count;
		int roll;
		int len;
		int k;
		start_count = work_items;
		while (work_items - start_count < budget) begin
			roll = $urandom_range(0, 99);
			if (roll < 55) begin
				queue_frame();
			end else if (roll < 70) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70)
						: $urandom_range(1, 8);
				for (k = 0; k < len; k++)
					queue_request(mdbrx_pkg::CMD_READ, 8'($urandom), 1'($urandom),
							1'($urandom));
			end else begin
				len = $urandom_range(1, 6);
				for (k = 0; k < len; k++)
					queue_request(2'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
			end
		end
	endtask

	// Wait until every request is sent and every result is back.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (request_queue.size() != 0 || req_ch.valid || expected_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// Write the mode register; the block is idle whenever this is called.
	task automatic set_mode(input logic m);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		model_mode = m;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Request driver: records accepted requests and presents the next one after a gap.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				expected_results.push_back(predict_frame_result(req_ch.payload));
				requests_taken++;
				if ($urandom_range(0, 99) == 0)
					calm <= !calm;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					req_ch.valid <= 1'b0;
				end else if (request_queue.size() != 0) begin
					req_ch.payload <= request_queue.pop_front();
					req_ch.valid <= 1'b1;
					send_gap <= pick_gap();
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compares each result with the oldest prediction, stalls at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result %0d %0d %02h %0b",
								$time, rsp_ch.payload.reply, rsp_ch.payload.frame_status,
								rsp_ch.payload.read_data, rsp_ch.payload.not_empty);
				end else begin
					want = expected_results.pop_front();
					results_checked++;
					if (want.reply == mdbrx_pkg::RP_ACK)
						ack_count++;
					if (want.reply == mdbrx_pkg::RP_NAK)
						nak_count++;
					if (want.reply == mdbrx_pkg::RP_NAK
							&& want.frame_status == mdbrx_pkg::ST_CKERR)
						ckerr_count++;
					if (want.reply == mdbrx_pkg::RP_NAK
							&& want.frame_status == mdbrx_pkg::ST_RANGE)
						full_count++;
					if (rsp_ch.payload.reply !== want.reply
							|| rsp_ch.payload.frame_status !== want.frame_status
							|| rsp_ch.payload.read_data !== want.read_data
							|| rsp_ch.payload.not_empty !== want.not_empty) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: result %0d expected %0d %0d %02h %0b, got %0d %0d %02h %0b",
									$time, results_checked, want.reply, want.frame_status,
									want.read_data, want.not_empty, rsp_ch.payload.reply,
									rsp_ch.payload.frame_status, rsp_ch.payload.read_data,
									rsp_ch.payload.not_empty);
					end
				end
			end
			if (hold_gap != 0) begin
				hold_gap <= hold_gap - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					hold_gap <= pick_gap();
			end
		end
	end

	// Watchdog: ends the run when neither channel moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("watchdog: nothing moved for %0d cycles", IDLE_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Stimulus: reset, directed cases in both modes, then random phases.
	initial begin
		int phase;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		rsp_ch.ready = 1'b0;
		model_mode = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// MDB framing: start-state last byte, sums, error states and reads.
		set_mode(1'b1);
		queue_request(mdbrx_pkg::CMD_RECV, 8'h5A, 1'b1, 1'b0);
		queue_request(mdbrx_pkg::CMD_CLEAR, 8'h00, 1'b0, 1'b0);
		queue_request(mdbrx_pkg::CMD_RECV, 8'h00, 1'b0, 1'b0);
		queue_request(mdbrx_pkg::CMD_RECV, 8'hFF, 1'b0, 1'b0);
		queue_request(mdbrx_pkg::CMD_RECV, 8'h33, 1'b0, 1'b1);
		queue_request(mdbrx_pkg::CMD_RECV, 8'hFF, 1'b1, 1'b0);
		queue_request(mdbrx_pkg::CMD_RECV, 8'h12, 1'b1, 1'b0);
		queue_request(mdbrx_pkg::CMD_RECV, 8'h80, 1'b0, 1'b0);
		queue_request(mdbrx_pkg::CMD_RECV, 8'h00, 1'b1, 1'b1);
		queue_request(mdbrx_pkg::CMD_RECV, 8'h44, 1'b1, 1'b0);
		queue_request(mdbrx_pkg::CMD_READ, 8'hFF, 1'b1, 1'b1);
		queue_request(mdbrx_pkg::CMD_READ, 8'h00, 1'b0, 1'b0);
		queue_request(mdbrx_pkg::CMD_CLEAR, 8'hFF, 1'b1, 1'b1);
		queue_request(mdbrx_pkg::CMD_READ, 8'h00, 1'b0, 1'b0);
		queue_request(CMD_UNUSED, 8'hA5, 1'b1, 1'b0);
		queue_request(mdbrx_pkg::CMD_RECV, 8'h01, 1'b0, 1'b0);
		queue_request(mdbrx_pkg::CMD_RECV, 8'h01, 1'b1, 1'b0);
		wait_drained();

		// Plain buffering: marked bytes are ignored, errored bytes dropped.
		set_mode(1'b0);
		queue_request(mdbrx_pkg::CMD_CLEAR, 8'h00, 1'b0, 1'b0);
		queue_request(mdbrx_pkg::CMD_RECV, 8'hAA, 1'b0, 1'b0);
		queue_request(mdbrx_pkg::CMD_RECV, 8'h55, 1'b1, 1'b0);
		queue_request(mdbrx_pkg::CMD_RECV, 8'h77, 1'b0, 1'b1);
		queue_request(mdbrx_pkg::CMD_READ, 8'h00, 1'b0, 1'b0);
		queue_request(mdbrx_pkg::CMD_READ, 8'hFF, 1'b1, 1'b1);

		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_drained();
			set_mode(phase % 2 == 0);
			fill_random_phase(PHASE_BUDGET);
		end
		wait_drained();
		repeat (10) @(posedge clk);
		mismatches += expected_results.size();

		$display("Ran %0d requests through %0d mode settings; %0d results checked.",
				requests_taken, RANDOM_PHASES + 2, results_checked);
		$display("Replies seen: %0d ACK, %0d NAK (%0d checksum errors, %0d buffer full).",
				ack_count, nak_count, ckerr_count, full_count);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
